>>> hw/rtl/ilir_pkg.sv
// shared types and constants of the indexed list unit
package ilir_pkg;

  localparam int unsigned ReqW     = 2;
  localparam int unsigned PosW     = 5;
  localparam int unsigned InWordW  = 32;
  localparam int unsigned OutWordW = 32;
  localparam int unsigned CountW   = 5;
  localparam int unsigned StatusW  = 2;

  typedef enum logic [ReqW-1:0] {
    REQ_APPEND = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_READ   = 2'd3
  } ilir_req_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_EMPTY = 2'd3
  } ilir_status_e;

  // shift control broadcast along the row of cells
  typedef struct packed {
    logic            append;
    logic            insert;
    logic            remove;
    logic [PosW-1:0] pos;
  } ilir_cell_ctrl_t;

endpackage

>>> hw/rtl/ilir_req_if.sv
// request channel: valid, ready and request payload
interface ilir_req_if;
  logic                         valid;
  logic                         ready;
  logic [ilir_pkg::ReqW-1:0]    req_type;
  logic [ilir_pkg::PosW-1:0]    position;
  logic [ilir_pkg::InWordW-1:0] word;

  modport source (output valid, req_type, position, word, input ready);
  modport sink   (input valid, req_type, position, word, output ready);
endinterface

>>> hw/rtl/ilir_rsp_if.sv
// response channel: valid, ready and result payload
interface ilir_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [ilir_pkg::OutWordW-1:0] read_word;
  logic [ilir_pkg::CountW-1:0]   count;
  logic [ilir_pkg::StatusW-1:0]  status;

  modport source (output valid, read_word, count, status, input ready);
  modport sink   (input valid, read_word, count, status, output ready);
endinterface

>>> hw/rtl/ilir_cell.sv
// one list cell: holds one entry and shifts to or from its neighbours
module ilir_cell #(
  parameter int unsigned WORD_WIDTH = 32,
  parameter int unsigned CW         = 5,
  parameter int unsigned IDX        = 0
) (
  input  logic                      clk_i,
  input  ilir_pkg::ilir_cell_ctrl_t ctrl_i,
  input  logic [CW-1:0]             count_i,
  input  logic [WORD_WIDTH-1:0]     word_i,
  input  logic [WORD_WIDTH-1:0]     left_i,
  input  logic [WORD_WIDTH-1:0]     right_i,
  output logic [WORD_WIDTH-1:0]     entry_o,
  output logic [WORD_WIDTH-1:0]     rd_o
);

  localparam int unsigned CmpW = ((CW > ilir_pkg::PosW) ? CW : ilir_pkg::PosW) + 1;

  logic [CmpW-1:0]       idx;
  logic [CmpW-1:0]       pos;
  logic [CmpW-1:0]       cnt;
  logic [WORD_WIDTH-1:0] entry_d;
  logic [WORD_WIDTH-1:0] entry_q;

  assign idx = CmpW'(IDX);
  assign pos = CmpW'(ctrl_i.pos);
  assign cnt = CmpW'(count_i);

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.append && (idx == cnt)) begin
      entry_d = word_i;
    end else if (ctrl_i.insert) begin
      if (idx == pos) begin
        entry_d = word_i;
      end else if ((idx > pos) && (idx <= cnt)) begin
        entry_d = left_i;
      end
    end else if (ctrl_i.remove && (idx >= pos) && ((idx + CmpW'(1)) < cnt)) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  // only the addressed cell drives its entry onto the read bus
  assign rd_o    = (idx == pos) ? entry_q : '0;

endmodule

>>> hw/rtl/indexed_list_insert_remove_unit.sv
// indexed list unit: ordered list of words with append, insert, remove and read
//
// req_i carries a request (req_type, position, word), rsp_o one result per
// request (read_word, count, status). Both are valid/ready channels; a
// transfer happens on a clock edge with valid and ready high.
// The list is a row of CAPACITY cells, one entry each. Insert and remove
// move every later entry by one place at once, each cell taking
// its neighbour's entry, so a request is done in the cycle of its transfer.
// The result sits in an output register and appears in the cycle after the
// request transfer. One request per cycle is sustained while rsp_o is taken.
// If the receiver stalls, the result is held and req_i.ready stays low until
// it is taken; a new request is accepted in the same cycle as the held
// result leaves.
// A failed request (full, out of range, empty) leaves the list unchanged.
// After reset the list is empty and no result is pending; entries are not
// cleared since only entries below the count are ever read.
module indexed_list_insert_remove_unit #(
  parameter int unsigned CAPACITY   = 16,
  parameter int unsigned WORD_WIDTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ilir_req_if.sink   req_i,
  ilir_rsp_if.source rsp_o
);

  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned CmpW = ((CW > ilir_pkg::PosW) ? CW : ilir_pkg::PosW) + 1;

  logic [WORD_WIDTH-1:0]         entry [CAPACITY];
  logic [WORD_WIDTH-1:0]         rd    [CAPACITY];
  logic [WORD_WIDTH-1:0]         rd_all;
  logic [WORD_WIDTH-1:0]         word_w;
  logic [63:0]                   w64;
  logic [63:0]                   rd64;
  ilir_pkg::ilir_cell_ctrl_t     ctrl;
  ilir_pkg::ilir_status_e        st;
  logic                          accept;
  logic                          full;
  logic                          empty;
  logic                          read_ok;
  logic [CmpW-1:0]               pos_x;
  logic [CmpW-1:0]               cnt_x;
  logic [CW-1:0]                 count_d, count_q;
  logic                          rsp_valid_d, rsp_valid_q;
  logic [ilir_pkg::OutWordW-1:0] rsp_word_d, rsp_word_q;
  logic [ilir_pkg::CountW-1:0]   rsp_count_q;
  ilir_pkg::ilir_status_e        rsp_status_q;

  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;

  assign w64    = 64'(req_i.word);
  assign word_w = w64[WORD_WIDTH-1:0];

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [WORD_WIDTH-1:0] left;
    logic [WORD_WIDTH-1:0] right;
    if (g == 0) begin : g_first
      assign left = '0;
    end else begin : g_left
      assign left = entry[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right = '0;
    end else begin : g_right
      assign right = entry[g+1];
    end
    ilir_cell #(
      .WORD_WIDTH (WORD_WIDTH),
      .CW         (CW),
      .IDX        (g)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .count_i (count_q),
      .word_i  (word_w),
      .left_i  (left),
      .right_i (right),
      .entry_o (entry[g]),
      .rd_o    (rd[g])
    );
  end

  always_comb begin
    rd_all = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_all = rd_all | rd[i];
    end
  end

  assign pos_x = CmpW'(req_i.position);
  assign cnt_x = CmpW'(count_q);
  assign full  = (count_q == CW'(CAPACITY));
  assign empty = (count_q == '0);

  always_comb begin
    st          = ilir_pkg::ST_OK;
    ctrl        = '0;
    ctrl.pos    = req_i.position;
    count_d     = count_q;
    read_ok     = 1'b0;
    case (ilir_pkg::ilir_req_e'(req_i.req_type))
      ilir_pkg::REQ_APPEND: begin
        if (full) begin
          st = ilir_pkg::ST_FULL;
        end else begin
          ctrl.append = accept;
          count_d     = count_q + CW'(1);
        end
      end
      ilir_pkg::REQ_INSERT: begin
        if (full) begin
          st = ilir_pkg::ST_FULL;
        end else if (pos_x > cnt_x) begin
          st = ilir_pkg::ST_RANGE;
        end else begin
          ctrl.insert = accept;
          count_d     = count_q + CW'(1);
        end
      end
      ilir_pkg::REQ_REMOVE: begin
        if (empty) begin
          st = ilir_pkg::ST_EMPTY;
        end else if (pos_x >= cnt_x) begin
          st = ilir_pkg::ST_RANGE;
        end else begin
          ctrl.remove = accept;
          count_d     = count_q - CW'(1);
        end
      end
      ilir_pkg::REQ_READ: begin
        if (pos_x >= cnt_x) begin
          st = ilir_pkg::ST_RANGE;
        end else begin
          read_ok = 1'b1;
        end
      end
      default: begin
        st = ilir_pkg::ST_OK;
      end
    endcase
  end

  assign rd64        = 64'(rd_all);
  assign rsp_word_d  = read_ok ? rd64[ilir_pkg::OutWordW-1:0] : '0;
  assign rsp_valid_d = accept ? 1'b1 : (rsp_o.ready ? 1'b0 : rsp_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      rsp_valid_q <= rsp_valid_d;
      if (accept) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_word_q   <= rsp_word_d;
      rsp_count_q  <= ilir_pkg::CountW'(count_d);
      rsp_status_q <= st;
    end
  end

  assign rsp_o.valid     = rsp_valid_q;
  assign rsp_o.read_word = rsp_word_q;
  assign rsp_o.count     = rsp_count_q;
  assign rsp_o.status    = rsp_status_q;

endmodule

>>> hw/rtl/ilir_checker.sv
// port-level checks of the indexed list unit and their bind
module ilir_checker #(
  parameter int unsigned CAPACITY = 16
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          rsp_valid_i,
  input logic                          rsp_ready_i,
  input logic [ilir_pkg::OutWordW-1:0] rsp_read_word_i,
  input logic [ilir_pkg::CountW-1:0]   rsp_count_i,
  input logic [ilir_pkg::StatusW-1:0]  rsp_status_i
);

  // a pending result stays until its transfer
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("result dropped before transfer");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (int'(rsp_count_i) <= int'(CAPACITY)))
    else $error("count above capacity");

  a_err_no_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_status_i != ilir_pkg::ST_OK) |-> (rsp_read_word_i == '0))
    else $error("failed request returned data");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_status_i == ilir_pkg::ST_EMPTY) |-> (rsp_count_i == '0))
    else $error("empty status with entries held");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_status_i == ilir_pkg::ST_FULL)
      |-> (rsp_count_i == ilir_pkg::CountW'(CAPACITY)))
    else $error("full status below capacity");

endmodule

bind indexed_list_insert_remove_unit ilir_checker #(
  .CAPACITY (CAPACITY)
) u_ilir_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .rsp_valid_i     (rsp_o.valid),
  .rsp_ready_i     (rsp_o.ready),
  .rsp_read_word_i (rsp_o.read_word),
  .rsp_count_i     (rsp_o.count),
  .rsp_status_i    (rsp_o.status)
);

>>> tb/sv/ilir_list_checker.sv
// checker of the indexed list unit: predicts each result and compares it
`timescale 1ns / 100ps

module ilir_list_checker import ilir_pkg::*; #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  ilir_req_if  req_mon,
  ilir_rsp_if  rsp_mon,
  output int   fail_count_o,
  output int   pending_o
);

  typedef struct packed {
    logic [OutWordW-1:0] read_word;
    logic [CountW-1:0]   count;
    ilir_status_e        status;
  } list_rsp_t;

  logic [InWordW-1:0] list_words [CAPACITY];
  int unsigned        list_len;
  list_rsp_t          pending_rsp_q [$];
  list_rsp_t          got_rsp;
  list_rsp_t          want_rsp;

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, want);
    fail_count_o++;
  endtask

  // applies one request to the local copy of the list
  function automatic list_rsp_t serve_request(ilir_req_e kind, logic [PosW-1:0] pos,
                                              logic [InWordW-1:0] w);
    list_rsp_t   r;
    int unsigned i;
    r.read_word = '0;
    r.status    = ST_OK;
    case (kind)
      REQ_APPEND: begin
        if (list_len >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          list_words[list_len] = w;
          list_len++;
        end
      end
      REQ_INSERT: begin
        // full is checked before range
        if (list_len >= CAPACITY) begin
          r.status = ST_FULL;
        end else if (pos > list_len) begin
          r.status = ST_RANGE;
        end else begin
          for (i = list_len; i > pos; i--) list_words[i] = list_words[i-1];
          list_words[pos] = w;
          list_len++;
        end
      end
      REQ_REMOVE: begin
        if (list_len == 0) begin
          r.status = ST_EMPTY;
        end else if (pos >= list_len) begin
          r.status = ST_RANGE;
        end else begin
          for (i = pos; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
          list_len--;
        end
      end
      default: begin
        if (pos >= list_len) begin
          r.status = ST_RANGE;
        end else begin
          r.read_word = list_words[pos];
        end
      end
    endcase
    r.count = CountW'(list_len);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      list_len = 0;
      pending_rsp_q.delete();
      pending_o <= 0;
    end else begin
      if (rsp_mon.valid && rsp_mon.ready) begin
        got_rsp.read_word = rsp_mon.read_word;
        got_rsp.count     = rsp_mon.count;
        got_rsp.status    = ilir_status_e'(rsp_mon.status);
        if (pending_rsp_q.size() == 0) begin
          report_mismatch("result with no request waiting", 32'(got_rsp), '0);
        end else begin
          want_rsp = pending_rsp_q.pop_front();
          if (got_rsp.read_word !== want_rsp.read_word)
            report_mismatch("read_word", got_rsp.read_word, want_rsp.read_word);
          if (got_rsp.count !== want_rsp.count)
            report_mismatch("count", 32'(got_rsp.count), 32'(want_rsp.count));
          if (got_rsp.status !== want_rsp.status)
            report_mismatch("status", 32'(got_rsp.status), 32'(want_rsp.status));
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        pending_rsp_q.push_back(serve_request(ilir_req_e'(req_mon.req_type),
                                              req_mon.position, req_mon.word));
      end
      pending_o <= pending_rsp_q.size();
    end
  end

endmodule

>>> tb/sv/tb.sv
// testbench top of the indexed list unit: stimulus, receiver stalls and verdict
`timescale 1ns / 100ps

module tb;
  import ilir_pkg::*;

  localparam int unsigned Capacity = 16;

  logic clk_i = 1'b0;
  logic rst_ni;
  int   tx_idle_pct;
  int   rx_idle_pct;
  int   fail_count;
  int   pending;

  ilir_req_if req_if ();
  ilir_rsp_if rsp_if ();

  indexed_list_insert_remove_unit #(
    .CAPACITY  (Capacity),
    .WORD_WIDTH(32)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  ilir_list_checker #(
    .CAPACITY(Capacity)
  ) u_list_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_mon     (req_if),
    .rsp_mon     (rsp_if),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    rsp_if.ready <= rst_ni && ($urandom_range(99) >= rx_idle_pct);
  end

  // one request transfer; valid stays high afterwards
  task automatic send_req(ilir_req_e kind, logic [PosW-1:0] pos, logic [InWordW-1:0] w);
    while ($urandom_range(99) < tx_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid    <= 1'b1;
    req_if.req_type <= kind;
    req_if.position <= pos;
    req_if.word     <= w;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  // holds the sender off until every result has come back
  task automatic wait_list_idle();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic run_random(int n_items);
    int          trend;
    int          roll;
    ilir_req_e   kind;
    logic [4:0]  pos;
    logic [31:0] w;
    for (int k = 0; k < n_items; k++) begin
      // bursts that lean towards filling, draining or neither
      if (k % 32 == 0) trend = $urandom_range(2);
      roll = $urandom_range(99);
      case (trend)
        0:       kind = roll < 45 ? REQ_APPEND : roll < 80 ? REQ_INSERT :
                        roll < 90 ? REQ_REMOVE : REQ_READ;
        1:       kind = roll < 10 ? REQ_APPEND : roll < 25 ? REQ_INSERT :
                        roll < 80 ? REQ_REMOVE : REQ_READ;
        default: kind = ilir_req_e'(roll % 4);
      endcase
      pos = ($urandom_range(9) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(16));
      roll = $urandom_range(19);
      w = roll == 0 ? 32'h0 : roll == 1 ? 32'hFFFF_FFFF : $urandom;
      send_req(kind, pos, w);
    end
  endtask

  initial begin
    req_if.valid    = 1'b0;
    req_if.req_type = '0;
    req_if.position = '0;
    req_if.word     = '0;
    rst_ni          = 1'b0;
    tx_idle_pct     = 11;
    rx_idle_pct     = 62;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty list corners
    send_req(REQ_READ,   5'd0, 32'h0);
    send_req(REQ_REMOVE, 5'd0, 32'h0);
    send_req(REQ_INSERT, 5'd1, 32'h1111_1111);
    send_req(REQ_INSERT, 5'd0, 32'h0);
    send_req(REQ_APPEND, 5'd31, 32'hFFFF_FFFF);
    // insert at the end acts as an append
    send_req(REQ_INSERT, 5'd2, 32'hA5A5_5A5A);
    send_req(REQ_INSERT, 5'd0, 32'h8000_0001);
    send_req(REQ_READ,   5'd31, 32'h0);
    send_req(REQ_REMOVE, 5'd4, 32'h0);
    send_req(REQ_REMOVE, 5'd1, 32'h0);
    for (int i = 0; i < 13; i++) send_req(REQ_APPEND, 5'd0, $urandom);
    send_req(REQ_APPEND, 5'd0, 32'hDEAD_0000);
    send_req(REQ_INSERT, 5'd0, 32'hDEAD_0001);
    send_req(REQ_READ,   5'd15, 32'h0);
    wait_list_idle();

    run_random(167);
    wait_list_idle();
    tx_idle_pct = 62;
    rx_idle_pct = 11;
    run_random(167);
    wait_list_idle();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_random(166);
    wait_list_idle();
    repeat (8) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("** indexed_list_insert_remove_unit: PASSED **");
    end else begin
      $display("** indexed_list_insert_remove_unit: FAILED **");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("** indexed_list_insert_remove_unit: FAILED **");
    $finish;
  end

endmodule
